/* rtl/core/fsms_pkg.sv */
package fsms_pkg;

	localparam int unsigned MAX_PATTERN = 8;
	localparam int unsigned MAX_TARGET  = 64;

	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_EMPTY    = 3'd1;
	localparam logic [2:0] KIND_EXACT    = 3'd2;
	localparam logic [2:0] KIND_PREFIX   = 3'd3;
	localparam logic [2:0] KIND_SUBSTR   = 3'd4;
	localparam logic [2:0] KIND_FUZZY    = 3'd5;
	localparam logic [2:0] KIND_ACRONYM  = 3'd6;
	localparam logic [2:0] KIND_TOO_LONG = 3'd7;

	localparam logic [15:0] SC_EXACT     = 16'd16000;
	localparam logic [15:0] SC_PREFIX    = 16'd9600;
	localparam logic [15:0] SC_SUBSTR    = 16'd6400;
	localparam logic [15:0] SC_BOUNDARY  = 16'd1600;
	localparam logic [15:0] SC_ACR_SUB   = 16'd800;
	localparam logic [15:0] SC_ACR_FUZZY = 16'd1600;
	localparam logic [15:0] SC_ACR_ONLY  = 16'd2400;
	localparam logic [11:0] RATIO_PREFIX = 12'd2400;
	localparam logic [11:0] RATIO_OTHER  = 12'd800;
	localparam logic [15:0] FZ_HIT       = 16'd160;
	localparam logic [15:0] FZ_WORD      = 16'd560;
	localparam logic [15:0] FZ_CONSEC    = 16'd400;
	localparam logic [15:0] FZ_GAP_STEP  = 16'd24;
	localparam logic [15:0] FZ_GAP_MAX   = 16'd320;
	localparam logic [15:0] SC_FLOOR     = 16'd16;

	localparam int unsigned NUM_W = 15;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        matched;
		logic [2:0]  match_kind;
		logic [13:0] score;
		logic [63:0] position_mask;
	} out_item_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [15:0]      base;
		logic [NUM_W-1:0] num;
		logic [6:0]       tlen;
		logic             clamp;
		logic [63:0]      mask;
	} job_t;

	function automatic logic is_up(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lo(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	function automatic logic is_an(input logic [7:0] c);
		return is_up(c) || is_lo(c) || ((c >= 8'h30) && (c <= 8'h39));
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return is_up(c) ? c + 8'd32 : c;
	endfunction

endpackage

/* rtl/core/fsms_fifo.sv */
module fsms_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  fsms_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          empty,
	output fsms_pkg::job_t rdata
);
	import fsms_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end

endmodule

/* rtl/core/fsms_front.sv */
module fsms_front #(
	parameter int unsigned MaxPattern = fsms_pkg::MAX_PATTERN,
	parameter int unsigned MaxTarget  = fsms_pkg::MAX_TARGET
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  fsms_pkg::in_item_t item,
	input  logic [63:0]       pattern_chars,
	input  logic [3:0]        pattern_length,
	output logic              job_valid,
	output fsms_pkg::job_t    job
);
	import fsms_pkg::*;

	logic [6:0]  cnt_q, cnt_n;
	logic [7:0]  rec_q [9];
	logic [7:0]  rec_n [9];
	logic        prefix_q, prefix_n;
	logic        sfound_q, sfound_n;
	logic [5:0]  spos_q, spos_n;
	logic        sbnd_q, sbnd_n;
	logic [7:0]  acr_q [8];
	logic [7:0]  acr_n [8];
	logic [6:0]  acnt_q, acnt_n;
	logic        afound_q, afound_n;
	logic        inword_q, inword_n;
	logic [3:0]  fidx_q, fidx_n;
	logic [5:0]  flast_q, flast_n;
	logic        fprev_q, fprev_n;
	logic [15:0] fscore_q, fscore_n;
	logic [63:0] fmask_q, fmask_n;
	logic        ovf_q, ovf_n;

	logic [3:0]  plen;
	logic [7:0]  pat [8];
	logic [7:0]  c, lc, prev;
	logic        word, bnd, ok, aok;
	logic [6:0]  gap;
	logic [15:0] pen;
	logic [63:0] ones;

	assign plen = (pattern_length > 4'(MaxPattern)) ? 4'(MaxPattern) : pattern_length;
	assign ones = ~(64'hFFFF_FFFF_FFFF_FFFF << plen);

	always_comb begin
		for (int i = 0; i < 8; i++) pat[i] = fold(pattern_chars[8*i +: 8]);
	end

	always_comb begin
		c    = item.ch;
		lc   = fold(c);
		prev = rec_q[0];
		cnt_n = cnt_q; prefix_n = prefix_q; sfound_n = sfound_q; spos_n = spos_q;
		sbnd_n = sbnd_q; acnt_n = acnt_q; afound_n = afound_q; inword_n = inword_q;
		fidx_n = fidx_q; flast_n = flast_q; fprev_n = fprev_q; fscore_n = fscore_q;
		fmask_n = fmask_q; ovf_n = ovf_q;
		rec_n = rec_q; acr_n = acr_q;
		word = is_an(c);
		bnd = 1'b0; ok = 1'b1; aok = 1'b1;
		gap = '0; pen = '0;
		if (cnt_q >= 7'(MaxTarget)) begin
			ovf_n = 1'b1;
		end else begin
			rec_n[0] = c;
			for (int k = 1; k < 9; k++) rec_n[k] = rec_q[k-1];
			if ((cnt_q < 7'(plen)) && (lc != pat[cnt_q[2:0]])) prefix_n = 1'b0;
			if (!sfound_q && (plen != 4'd0) && ((cnt_q + 7'd1) >= 7'(plen))) begin
				for (int k = 0; k < 8; k++) begin
					if ((4'(k) < plen) && (fold(rec_n[k]) != pat[3'(plen - 4'd1 - 4'(k))]))
						ok = 1'b0;
				end
				if (ok) begin
					sfound_n = 1'b1;
					spos_n   = 6'(cnt_q + 7'd1 - 7'(plen));
					sbnd_n   = (spos_n == 6'd0) || !is_an(rec_n[plen]);
				end
			end
			bnd = word && (!inword_q || (is_up(c) && (cnt_q != 7'd0) && is_lo(prev)));
			if (bnd) begin
				acr_n[0] = lc;
				for (int k = 1; k < 8; k++) acr_n[k] = acr_q[k-1];
				if (acnt_q < 7'd127) acnt_n = acnt_q + 7'd1;
				if ((plen != 4'd0) && (acnt_n >= 7'(plen))) begin
					for (int k = 0; k < 8; k++) begin
						if ((4'(k) < plen) && (acr_n[k] != pat[3'(plen - 4'd1 - 4'(k))]))
							aok = 1'b0;
					end
					if (aok) afound_n = 1'b1;
				end
			end
			inword_n = word;
			if (fidx_q < plen) begin
				if (lc == pat[fidx_q[2:0]]) begin
					fmask_n[cnt_q[5:0]] = 1'b1;
					fscore_n = fscore_q + FZ_HIT;
					if ((cnt_q == 7'd0) || !is_an(prev) || (is_up(c) && is_lo(prev)))
						fscore_n = fscore_n + FZ_WORD;
					if (fprev_q && (cnt_q == ({1'b0, flast_q} + 7'd1))) begin
						fscore_n = fscore_n + FZ_CONSEC;
					end else if (fidx_q != 4'd0) begin
						gap = cnt_q - {1'b0, flast_q} - 7'd1;
						pen = (gap > 7'd13) ? FZ_GAP_MAX : 16'(gap) * FZ_GAP_STEP;
						fscore_n = fscore_n - pen;
					end
					fprev_n = 1'b1;
					flast_n = cnt_q[5:0];
					fidx_n  = fidx_q + 4'd1;
				end else begin
					fprev_n = 1'b0;
				end
			end
			cnt_n = cnt_q + 7'd1;
		end
	end

	// classify the finished string and set up the ratio term for the back end
	always_comb begin
		job = '0;
		job.tlen = cnt_n;
		if (ovf_n) begin
			job.kind = KIND_TOO_LONG;
		end else if (plen == 4'd0) begin
			job.kind = KIND_EMPTY;
		end else if ((7'(plen) > cnt_n) || (cnt_n == 7'd0)) begin
			job.kind = KIND_NONE;
		end else if (prefix_n && (cnt_n == 7'(plen))) begin
			job.kind = KIND_EXACT;
			job.base = SC_EXACT;
			job.mask = ones;
		end else if (prefix_n) begin
			job.kind = KIND_PREFIX;
			job.base = SC_PREFIX;
			job.num  = NUM_W'(RATIO_PREFIX) * NUM_W'(plen);
			job.mask = ones;
		end else if (sfound_n) begin
			job.kind = KIND_SUBSTR;
			job.base = SC_SUBSTR + (sbnd_n ? SC_BOUNDARY : 16'd0)
				+ (afound_n ? SC_ACR_SUB : 16'd0);
			job.num  = NUM_W'(RATIO_OTHER) * NUM_W'(plen);
			job.mask = ones << spos_n;
		end else if (fidx_n == plen) begin
			job.kind  = KIND_FUZZY;
			job.base  = fscore_n + (afound_n ? SC_ACR_FUZZY : 16'd0);
			job.num   = NUM_W'(RATIO_OTHER) * NUM_W'(plen);
			job.clamp = 1'b1;
			job.mask  = fmask_n;
		end else if (afound_n) begin
			job.kind = KIND_ACRONYM;
			job.base = SC_ACR_ONLY;
		end
	end

	assign job_valid = accept && item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; prefix_q <= 1'b1; sfound_q <= 1'b0; spos_q <= '0; sbnd_q <= 1'b0;
			acnt_q <= '0; afound_q <= 1'b0; inword_q <= 1'b0; fidx_q <= '0; flast_q <= '0;
			fprev_q <= 1'b0; fscore_q <= '0; fmask_q <= '0; ovf_q <= 1'b0;
			for (int k = 0; k < 9; k++) rec_q[k] <= '0;
			for (int k = 0; k < 8; k++) acr_q[k] <= '0;
		end else if (accept) begin
			if (item.last) begin
				cnt_q <= '0; prefix_q <= 1'b1; sfound_q <= 1'b0; spos_q <= '0; sbnd_q <= 1'b0;
				acnt_q <= '0; afound_q <= 1'b0; inword_q <= 1'b0; fidx_q <= '0;
				flast_q <= '0; fprev_q <= 1'b0; fscore_q <= '0; fmask_q <= '0; ovf_q <= 1'b0;
				for (int k = 0; k < 9; k++) rec_q[k] <= '0;
				for (int k = 0; k < 8; k++) acr_q[k] <= '0;
			end else begin
				cnt_q <= cnt_n; prefix_q <= prefix_n; sfound_q <= sfound_n; spos_q <= spos_n;
				sbnd_q <= sbnd_n; acnt_q <= acnt_n; afound_q <= afound_n;
				inword_q <= inword_n; fidx_q <= fidx_n; flast_q <= flast_n;
				fprev_q <= fprev_n; fscore_q <= fscore_n; fmask_q <= fmask_n; ovf_q <= ovf_n;
				rec_q <= rec_n;
				acr_q <= acr_n;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'(MaxTarget)) else $error("character count beyond target limit");
	a_fidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q <= 4'(MaxPattern)) else $error("fuzzy index beyond pattern limit");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |=> (cnt_q == 7'd0) && !ovf_q && prefix_q)
		else $error("string state not cleared after final beat");

endmodule

/* rtl/core/fsms_back.sv */
module fsms_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  fsms_pkg::job_t     q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_take,
	output fsms_pkg::out_item_t out_item
);
	import fsms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t           state_q;
	job_t             job_q;
	logic [NUM_W-1:0] num_q, quo_q;
	logic [6:0]       rem_q, div_q;
	logic [3:0]       cnt_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [7:0]  rem_sh;
	logic        ge;
	logic [16:0] sum;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign rem_sh    = {rem_q, num_q[NUM_W-1]};
	assign ge        = rem_sh >= {1'b0, div_q};

	always_comb begin
		sum = 17'($signed({job_q.base[15], job_q.base}) + $signed({2'b00, quo_q}));
		if (job_q.clamp && ($signed(sum) < $signed({1'b0, SC_FLOOR}))) sum = {1'b0, SC_FLOOR};
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
			num_q <= q_data.num;
			div_q <= (q_data.tlen == 7'd0) ? 7'd1 : q_data.tlen;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? 7'(rem_sh - {1'b0, div_q}) : rem_sh[6:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
			num_q <= num_q << 1;
		end
		if ((state_q == ST_DONE) && (!out_valid_q || out_take)) begin
			out_q.match_kind    <= job_q.kind;
			out_q.matched       <= (job_q.kind != KIND_NONE) && (job_q.kind != KIND_TOO_LONG);
			out_q.score         <= sum[13:0];
			out_q.position_mask <= job_q.mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || out_take)) out_valid_q <= 1'b1;
			else if (out_take && out_valid_q)                      out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(NUM_W - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_take) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < 4'(NUM_W))) else $error("divide step count overrun");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && !out_valid_q) |=> out_valid_q)
		else $error("finished result not loaded");
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.matched) |-> (out_q.score == 14'd0) && (out_q.position_mask == '0))
		else $error("unmatched result carries score or mask");

endmodule

/* rtl/core/fuzzy_string_match_scorer_unit.sv */
// Fuzzy string match scorer.
// Configuration: APB-style port. pattern_chars at byte address 0 (64 bits,
// char i in bits 8i+7:8i), pattern_length at address 8. Write only while idle.
// Input: push/full queue port. Each beat carries one target character and a
// last flag; one beat is taken per cycle while full is low.
// Output: empty/pop queue port. One result beat per string, produced after
// the beat marked last: matched, match kind, score (1/16 units), position mask.
// Flow: the front end folds each character into running match state in
// the cycle it is taken. On the last beat it pushes a job into a two-entry
// queue. The back end pops a job while idle, divides the ratio term one
// quotient bit per cycle, then loads the result register, which drives
// empty low. It takes no new job until that result is loaded, so when
// strings arrive faster than it finishes them the queue fills and full
// throttles the input.
// Reset clears all string state, the queue and the result valid flag; the
// pattern registers read zero (empty pattern).
// When the receiver stalls, hold the result; the back end keeps one finished
// job waiting and the queue fills, after which full rises.
module fuzzy_string_match_scorer_unit #(
	parameter int unsigned MaxPattern = fsms_pkg::MAX_PATTERN,
	parameter int unsigned MaxTarget  = fsms_pkg::MAX_TARGET
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                push,
	output logic                full,
	input  fsms_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output fsms_pkg::out_item_t out_item
);
	import fsms_pkg::*;

	logic [63:0] pattern_chars_q;
	logic [3:0]  pattern_length_q;
	logic        accept, job_valid, q_empty, q_pop, out_valid;
	job_t        job, q_data;

	assign pready = 1'b1;
	// register select by paddr[3]: low half pattern bytes, high half length
	assign prdata = paddr[3] ? {60'd0, pattern_length_q} : pattern_chars_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_chars_q  <= '0;
			pattern_length_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[3]) pattern_length_q <= pwdata[3:0];
			else          pattern_chars_q  <= pwdata;
		end
	end

	// take a beat whenever the job queue has room
	assign accept = push && !full;
	assign empty  = !out_valid;

	fsms_front #(.MaxPattern(MaxPattern), .MaxTarget(MaxTarget)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(in_item),
		.pattern_chars(pattern_chars_q), .pattern_length(pattern_length_q),
		.job_valid(job_valid), .job(job)
	);

	fsms_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(job_valid), .wdata(job), .full(full),
		.rd(q_pop), .empty(q_empty), .rdata(q_data)
	);

	fsms_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
		.out_valid(out_valid), .out_take(pop), .out_item(out_item)
	);

endmodule

/* bench/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fsms_pkg::*;

	localparam logic [3:0] ADDR_CHARS = 4'd0;
	localparam logic [3:0] ADDR_LEN   = 4'd8;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [3:0]          paddr;
	logic [63:0]         pwdata;
	logic [63:0]         prdata;
	logic                pready;
	logic                push;
	logic                full;
	in_item_t            in_item;
	logic                empty;
	logic                pop;
	out_item_t           out_item;

	fuzzy_string_match_scorer_unit DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .in_item(in_item), .empty(empty), .pop(pop),
		.out_item(out_item)
	);

	// Shadow copy of the pattern registers.
	logic [63:0] pat_chars;
	logic [3:0]  pat_len_reg;

	// Running match state of the string in flight.
	int unsigned n_chars;
	logic [7:0]  hist [9];
	bit          pfx_ok;
	bit          sub_hit;
	int unsigned sub_at;
	bit          sub_bnd;
	logic [7:0]  acr_hist [8];
	int unsigned acr_n;
	bit          acr_hit;
	bit          word_on;
	int unsigned fz_idx;
	int unsigned fz_last;
	bit          fz_prev;
	int          fz_sum;
	logic [63:0] fz_bits;
	bit          too_long;

	out_item_t   score_queue [$];
	int          errors;
	bit          quiet;
	bit          hold_off;

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit upper_ch(input logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic bit lower_ch(input logic [7:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic bit alnum(input logic [7:0] c);
		return upper_ch(c) || lower_ch(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic logic [7:0] pat_ch(input int unsigned i);
		return lower(pat_chars[(i % 8) * 8 +: 8]);
	endfunction

	function automatic int unsigned eff_len();
		return (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
	endfunction

	task automatic clear_match();
		n_chars = 0;
		foreach (hist[k]) hist[k] = '0;
		foreach (acr_hist[k]) acr_hist[k] = '0;
		pfx_ok = 1; sub_hit = 0; sub_at = 0; sub_bnd = 0;
		acr_n = 0; acr_hit = 0; word_on = 0;
		fz_idx = 0; fz_last = 0; fz_prev = 0; fz_sum = 0; fz_bits = '0;
		too_long = 0;
	endtask

	// Fold one character into the running state.
	task automatic fold_char(input logic [7:0] c, input int unsigned pl);
		int unsigned idx;
		logic [7:0]  prv;
		logic [7:0]  lc;
		bit          ok;
		bit          bnd;
		bit          wd;
		int unsigned pen;
		idx = n_chars;
		prv = hist[0];
		lc = lower(c);
		for (int k = 8; k > 0; k--) hist[k] = hist[k-1];
		hist[0] = c;
		if (idx < pl && lc != pat_ch(idx)) pfx_ok = 0;
		if (!sub_hit && pl > 0 && idx + 1 >= pl) begin
			ok = 1;
			for (int k = 0; k < pl; k++)
				if (lower(hist[k]) != pat_ch(pl - 1 - k)) ok = 0;
			if (ok) begin
				sub_hit = 1;
				sub_at = idx + 1 - pl;
				sub_bnd = (sub_at == 0) || !alnum(hist[pl]);
			end
		end
		wd = alnum(c);
		bnd = wd && (!word_on || (upper_ch(c) && idx > 0 && lower_ch(prv)));
		if (bnd) begin
			for (int k = 7; k > 0; k--) acr_hist[k] = acr_hist[k-1];
			acr_hist[0] = lc;
			if (acr_n < 127) acr_n++;
			if (pl > 0 && acr_n >= pl) begin
				ok = 1;
				for (int k = 0; k < pl; k++)
					if (acr_hist[k] != pat_ch(pl - 1 - k)) ok = 0;
				if (ok) acr_hit = 1;
			end
		end
		word_on = wd;
		if (fz_idx < pl) begin
			if (lc == pat_ch(fz_idx)) begin
				fz_bits[idx % 64] = 1'b1;
				fz_sum += 160;
				if (idx == 0 || !alnum(prv) || (upper_ch(c) && lower_ch(prv))) fz_sum += 560;
				if (fz_prev && idx == fz_last + 1) begin
					fz_sum += 400;
				end else if (fz_idx > 0) begin
					pen = (idx - fz_last - 1) * 24;
					if (pen > 320) pen = 320;
					fz_sum -= int'(pen);
				end
				fz_prev = 1;
				fz_last = idx;
				fz_idx++;
			end else begin
				fz_prev = 0;
			end
		end
		n_chars = idx + 1;
	endtask

	// Advance the predictor by one beat; queue a score when last is set.
	task automatic predict_score(input in_item_t it);
		int unsigned pl;
		int unsigned tl;
		int          sc;
		out_item_t   r;
		pl = eff_len();
		if (n_chars >= MAX_TARGET) too_long = 1;
		else fold_char(it.ch, pl);
		if (!it.last) return;
		tl = n_chars;
		r = '0;
		sc = 0;
		if (too_long) begin
			r.match_kind = KIND_TOO_LONG;
		end else if (pl == 0) begin
			r.matched = 1; r.match_kind = KIND_EMPTY;
		end else if (pl > tl || tl == 0) begin
			r.match_kind = KIND_NONE;
		end else if (pfx_ok && tl == pl) begin
			r.matched = 1; r.match_kind = KIND_EXACT; sc = 16000;
			r.position_mask = (64'd1 << pl) - 1;
		end else if (pfx_ok) begin
			r.matched = 1; r.match_kind = KIND_PREFIX;
			sc = 9600 + int'((2400 * pl) / tl);
			r.position_mask = (64'd1 << pl) - 1;
		end else if (sub_hit) begin
			r.matched = 1; r.match_kind = KIND_SUBSTR;
			sc = 6400 + (sub_bnd ? 1600 : 0) + int'((800 * pl) / tl) + (acr_hit ? 800 : 0);
			r.position_mask = ((64'd1 << pl) - 1) << (sub_at % 64);
		end else if (fz_idx == pl) begin
			r.matched = 1; r.match_kind = KIND_FUZZY;
			sc = fz_sum + (acr_hit ? 1600 : 0) + int'((800 * pl) / tl);
			if (sc < 16) sc = 16;
			r.position_mask = fz_bits;
		end else if (acr_hit) begin
			r.matched = 1; r.match_kind = KIND_ACRONYM; sc = 2400;
		end
		r.score = sc[13:0];
		score_queue = {score_queue, r};
		clear_match();
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Output side: random pop bursts, long hold-off on request.
	initial begin
		int gap;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off || (!quiet && $urandom_range(0, 5) == 0)) begin
				gap = $urandom_range(1, 9);
				pop <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Check every accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (score_queue.size() == 0) begin
				report("unexpected beat", out_item.position_mask, 64'd0);
			end else begin
				want = score_queue.pop_front();
				if (out_item.matched !== want.matched)
					report("matched", 64'(out_item.matched), 64'(want.matched));
				if (out_item.match_kind !== want.match_kind)
					report("match_kind", 64'(out_item.match_kind), 64'(want.match_kind));
				if (out_item.score !== want.score)
					report("score", 64'(out_item.score), 64'(want.score));
				if (out_item.position_mask !== want.position_mask)
					report("position_mask", out_item.position_mask, want.position_mask);
			end
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_CHARS) pat_chars = data;
		else pat_len_reg = data[3:0];
	endtask

	// Drain outstanding results, then let the back end settle.
	task automatic wait_idle();
		while (score_queue.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_pattern(input logic [63:0] chars, input logic [3:0] len);
		wait_idle();
		reg_write(ADDR_CHARS, chars);
		reg_write(ADDR_LEN, len);
	endtask

	// Offer one beat; hold push until accepted.
	task automatic send_char(input logic [7:0] c, input bit lst, input bit idle_ok);
		in_item_t it;
		int gap;
		if (idle_ok && !quiet && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 9);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.ch = c;
		it.last = lst;
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		predict_score(it);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, 1);
	endtask

	task automatic end_push();
		push <= 1'b0;
	endtask

	// Pick a character that is often near the pattern.
	function automatic logic [7:0] pick_char();
		int unsigned pl;
		logic [7:0] c;
		pl = eff_len();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				c = pat_chars[$urandom_range(0, (pl == 0 ? 1 : pl) - 1) * 8 +: 8];
				if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
			end
			4: c = " ";
			5: c = "_";
			6: c = 8'($urandom_range(0, 255));
			default: c = 8'($urandom_range("a", "z"));
		endcase
		return c;
	endfunction

	function automatic logic [63:0] rand_pattern();
		logic [63:0] p;
		for (int i = 0; i < 8; i++)
			p[i*8 +: 8] = $urandom_range(0, 4) == 0 ? 8'($urandom_range("A", "Z"))
			                                     : 8'($urandom_range("a", "d"));
		return p;
	endfunction

	typedef struct {
		logic [63:0] chars;
		logic [3:0]  len;
		string       text;
		bit          typed;
		out_item_t   want;
	} dir_row_t;

	dir_row_t rows [$];

	task automatic add_row(input logic [63:0] chars, input logic [3:0] len, input string text,
	                       input bit typed, input out_item_t want);
		dir_row_t nr;
		nr.chars = chars;
		nr.len   = len;
		nr.text  = text;
		nr.typed = typed;
		nr.want  = want;
		rows = {rows, nr};
	endtask

	initial begin
		dir_row_t  row;
		out_item_t ovf_want;
		int        sent;
		int        tl;
		int        pl;
		errors = 0;
		quiet = 0;
		hold_off = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		push = 1'b0; in_item = '0;
		pat_chars = '0; pat_len_reg = '0;
		clear_match();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table; typed rows carry an obvious answer.
		add_row(64'h0, 4'd0, "x", 1, '{1'b1, KIND_EMPTY, 14'd0, 64'd0});
		add_row("cba", 4'd3, "ABC", 1, '{1'b1, KIND_EXACT, 14'd16000, 64'h7});
		add_row("cba", 4'd3, "ab", 1, '{1'b0, KIND_NONE, 14'd0, 64'd0});
		add_row("cba", 4'd3, "zzz", 1, '{1'b0, KIND_NONE, 14'd0, 64'd0});
		add_row("cba", 4'd3, "abcdef", 0, '0);
		add_row("cba", 4'd3, "xx abc", 0, '0);
		add_row("cba", 4'd3, "xxabcx", 0, '0);
		add_row("cba", 4'd3, "aXbXc", 0, '0);
		add_row("cba", 4'd3, "alphaBetaCat", 0, '0);
		add_row("cba", 4'd3, "a-b-c", 0, '0);
		add_row("cba", 4'd3, "aqqqqqqqqqqqqqqqqqqqbc", 0, '0);
		add_row("fedcba", 4'd6, "a bc dxef", 0, '0);
		add_row("ba", 4'd2, "xAyB", 0, '0);
		add_row("hgfedcba", 4'd15, "ABCDEFGH", 1, '{1'b1, KIND_EXACT, 14'd16000, 64'hFF});
		add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, "\377\377\377\377\377\377\377\377", 1,
		        '{1'b1, KIND_EXACT, 14'd16000, 64'hFF});
		add_row("a", 4'd1, "a", 1, '{1'b1, KIND_EXACT, 14'd16000, 64'h1});
		foreach (rows[r]) begin
			row = rows[r];
			if (row.chars != pat_chars || row.len != pat_len_reg) begin
				end_push();
				set_pattern(row.chars, row.len);
			end
			if (row.typed) begin
				send_string(row.text);
				void'(score_queue.pop_back());
				score_queue = {score_queue, row.want};
			end else begin
				send_string(row.text);
			end
		end
		// Length limit: 70 characters (too long), exactly 64 (at the limit), and an empty-pattern overflow.
		for (int i = 0; i < 70; i++) send_char("a", i == 69, 1);
		for (int i = 0; i < 64; i++) send_char("a", i == 63, 1);
		end_push();
		set_pattern(64'h0, 4'd0);
		for (int i = 0; i < 66; i++) send_char(8'h80, i == 65, 1);
		void'(score_queue.pop_back());
		ovf_want = '{1'b0, KIND_TOO_LONG, 14'd0, 64'd0};
		score_queue = {score_queue, ovf_want};

		// Fill the block while the receiver holds off.
		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 40; i++) send_char("q", 1, 0);
		join

		// Random strings, mostly near the pattern.
		sent = 0;
		while (sent < 1460) begin
			if ($urandom_range(0, 40) == 0) begin
				end_push();
				pl = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) pl = ($urandom_range(0, 1)) ? 0 : 15;
				set_pattern($urandom_range(0, 5) == 0 ? {$urandom, $urandom} : rand_pattern(),
				            pl[3:0]);
			end
			if (sent > 1200) quiet = 1;
			tl = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 14);
			for (int i = 0; i < tl; i++) send_char(pick_char(), i == tl - 1, 1);
			sent += tl;
		end
		end_push();
		wait_idle();
		if (errors == 0) begin
			$display("PASS fuzzy_string_match_scorer_unit");
		end else begin
			$display("FAIL fuzzy_string_match_scorer_unit");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL fuzzy_string_match_scorer_unit");
		$finish;
	end
endmodule

/* files.f */
rtl/core/fsms_pkg.sv
rtl/core/fsms_fifo.sv
rtl/core/fsms_front.sv
rtl/core/fsms_back.sv
rtl/core/fuzzy_string_match_scorer_unit.sv
bench/tb.sv
